### rtl/usb_hid_descriptor_scanner_defines.svh
`ifndef USB_HID_DESCRIPTOR_SCANNER_DEFINES_SVH
`define USB_HID_DESCRIPTOR_SCANNER_DEFINES_SVH

// Implication check on a given clock and synchronous reset.
`define HDS_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Same check on the block's own clk and rst.
`define HDS_CHECK(name, ante, cons, msg) \
  `HDS_ASSERT_IMPL(name, clk, rst, ante, cons, msg)

`endif

### rtl/hds_pkg.sv
package hds_pkg;

  localparam logic [7:0] DESC_TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'h05;
  localparam logic [1:0] EP_TYPE_MASK        = 2'h3;
  localparam logic [1:0] EP_TYPE_INTERRUPT   = 2'h3;
  localparam int         EP_DIR_IN_BIT       = 7;
  localparam logic [7:0] TARGET_CLASS_RESET  = 8'h03;

  localparam logic [7:0] OFF_LENGTH = 8'd0;
  localparam logic [7:0] OFF_TYPE   = 8'd1;
  localparam logic [7:0] OFF_IF_NUM = 8'd2;
  localparam logic [7:0] OFF_IF_CLS = 8'd5;
  localparam logic [7:0] OFF_EP_ADR = 8'd2;
  localparam logic [7:0] OFF_EP_ATR = 8'd3;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_ZERO_LEN  = 2'd2
  } hds_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hds_item_t;

  typedef struct packed {
    hds_status_t scan_status;
    logic [7:0]  iface_id;
    logic [7:0]  endpoint_address;
  } hds_result_t;

endpackage

### rtl/hds_if.sv
interface hds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hds_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] scan_status;
  logic [7:0] iface_id;
  logic [7:0] endpoint_address;

  modport source (output valid, output scan_status, output iface_id,
                  output endpoint_address, input ready);
  modport sink (input valid, input scan_status, input iface_id,
                input endpoint_address, output ready);
endinterface

interface hds_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] target_class;

  modport source (output valid, output target_class, input ready);
  modport sink (input valid, input target_class, output ready);
endinterface

### rtl/hds_in_stage.sv
module hds_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hds_pkg::hds_item_t in_item,
  output logic              item_valid,
  output hds_pkg::hds_item_t item,
  input  logic              item_take
);

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

### rtl/hds_scan.sv
module hds_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_target_class,
  input  logic                step,
  input  hds_pkg::hds_item_t  item,
  output logic                emit,
  output hds_pkg::hds_result_t result
);

  logic [7:0] target_class;

  logic [7:0] byte_offset,       byte_offset_next;
  logic [7:0] descriptor_length, descriptor_length_next;
  logic [7:0] descriptor_type,   descriptor_type_next;
  logic [7:0] active_iface,      active_iface_next;
  logic       class_matched,     class_matched_next;
  logic [7:0] held_endpoint,     held_endpoint_next;
  logic       scan_done,         scan_done_next;
  logic [8:0] offset_inc;

  assign offset_inc = {1'b0, byte_offset} + 9'd1;

  always_comb begin
    byte_offset_next       = byte_offset;
    descriptor_length_next = descriptor_length;
    descriptor_type_next   = descriptor_type;
    active_iface_next      = active_iface;
    class_matched_next     = class_matched;
    held_endpoint_next     = held_endpoint;
    scan_done_next         = scan_done;
    emit                   = 1'b0;
    result                 = '0;

    if (!scan_done) begin
      priority if (byte_offset == hds_pkg::OFF_LENGTH) begin
        descriptor_length_next = item.data_byte;
        descriptor_type_next   = '0;
        if (item.data_byte == 8'd0) begin
          emit               = 1'b1;
          result.scan_status = hds_pkg::ST_ZERO_LEN;
          scan_done_next     = 1'b1;
        end
      end else if (byte_offset == hds_pkg::OFF_TYPE) begin
        descriptor_type_next = item.data_byte;
        if (item.data_byte == hds_pkg::DESC_TYPE_INTERFACE) begin
          active_iface_next  = '0;
          class_matched_next = 1'b0;
        end else if (item.data_byte == hds_pkg::DESC_TYPE_ENDPOINT) begin
          held_endpoint_next = '0;
        end
      end else if (descriptor_type == hds_pkg::DESC_TYPE_INTERFACE) begin
        if (byte_offset == hds_pkg::OFF_IF_NUM) begin
          active_iface_next = item.data_byte;
        end else if (byte_offset == hds_pkg::OFF_IF_CLS) begin
          class_matched_next = (item.data_byte == target_class);
        end
      end else begin
        // endpoint fields only count under a matching interface
        if (descriptor_type == hds_pkg::DESC_TYPE_ENDPOINT && class_matched) begin
          if (byte_offset == hds_pkg::OFF_EP_ADR) begin
            held_endpoint_next = item.data_byte;
          end else if (byte_offset == hds_pkg::OFF_EP_ATR) begin
            if ((item.data_byte[1:0] & hds_pkg::EP_TYPE_MASK) ==
                hds_pkg::EP_TYPE_INTERRUPT &&
                held_endpoint[hds_pkg::EP_DIR_IN_BIT]) begin
              emit                    = 1'b1;
              result.scan_status      = hds_pkg::ST_FOUND;
              result.iface_id         = active_iface;
              result.endpoint_address = held_endpoint;
              scan_done_next          = 1'b1;
            end
          end
        end
      end

      // length compare uses the length just captured on the first byte
      if (!scan_done_next) begin
        byte_offset_next = (offset_inc >= {1'b0, descriptor_length_next}) ? '0
                                                                          : offset_inc[7:0];
      end

      if (item.last_byte && !scan_done_next) begin
        emit               = 1'b1;
        result.scan_status = hds_pkg::ST_NOT_FOUND;
      end
    end

    // end of blob re-arms the scan
    if (item.last_byte) begin
      byte_offset_next       = '0;
      descriptor_length_next = '0;
      descriptor_type_next   = '0;
      active_iface_next      = '0;
      class_matched_next     = 1'b0;
      held_endpoint_next     = '0;
      scan_done_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_class <= hds_pkg::TARGET_CLASS_RESET;
    end else if (cfg_valid) begin
      target_class <= cfg_target_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset       <= '0;
      descriptor_length <= '0;
      descriptor_type   <= '0;
      active_iface      <= '0;
      class_matched     <= 1'b0;
      held_endpoint     <= '0;
      scan_done         <= 1'b0;
    end else if (step) begin
      byte_offset       <= byte_offset_next;
      descriptor_length <= descriptor_length_next;
      descriptor_type   <= descriptor_type_next;
      active_iface      <= active_iface_next;
      class_matched     <= class_matched_next;
      held_endpoint     <= held_endpoint_next;
      scan_done         <= scan_done_next;
    end
  end

endmodule

### rtl/hds_out_stage.sv
module hds_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 accept,
  input  logic                 load,
  input  hds_pkg::hds_result_t load_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hds_pkg::hds_result_t out_data
);

  assign accept = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && load) begin
      out_data <= load_data;
    end
  end

endmodule

### rtl/usb_hid_descriptor_scanner.sv
// Datapath: a byte is registered in the input register, the scan result for it is registered
// in the result register, and the result transaction is taken from there.
// Throughput: one byte per cycle while the result side is ready. A result waiting in the
// result register holds the scan; the input register takes one more byte, then input stalls.
// Reset (rst, synchronous): clears the scan state, both stage valids, and sets
// target_class to 3. The configuration port is always ready.
`include "usb_hid_descriptor_scanner_defines.svh"

module usb_hid_descriptor_scanner (
  input  logic      clk,
  input  logic      rst,
  hds_in_if.sink    descriptor,
  hds_out_if.source result,
  hds_cfg_if.sink   cfg
);

  hds_pkg::hds_item_t   in_item;
  hds_pkg::hds_item_t   item;
  logic                 item_valid;
  logic                 step;
  logic                 accept;
  logic                 emit;
  hds_pkg::hds_result_t scan_result;
  hds_pkg::hds_result_t out_data;

  assign in_item.data_byte = descriptor.data_byte;
  assign in_item.last_byte = descriptor.last_byte;
  assign cfg.ready         = 1'b1;
  assign step              = item_valid && accept;

  hds_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (descriptor.valid),
    .in_ready   (descriptor.ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (step)
  );

  hds_scan u_scan (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg.valid),
    .cfg_target_class (cfg.target_class),
    .step             (step),
    .item             (item),
    .emit             (emit),
    .result           (scan_result)
  );

  hds_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .load      (step && emit),
    .load_data (scan_result),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  assign result.scan_status      = out_data.scan_status;
  assign result.iface_id         = out_data.iface_id;
  assign result.endpoint_address = out_data.endpoint_address;

  `HDS_CHECK(a_found_is_in_ep,
             result.valid && result.scan_status == hds_pkg::ST_FOUND,
             result.endpoint_address[hds_pkg::EP_DIR_IN_BIT],
             "found endpoint is not an IN endpoint")
  `HDS_CHECK(a_miss_fields_zero,
             result.valid && result.scan_status != hds_pkg::ST_FOUND,
             result.iface_id == 8'd0 && result.endpoint_address == 8'd0,
             "fields nonzero on a result that is not found")
  `HDS_CHECK(a_status_legal,
             result.valid,
             result.scan_status == hds_pkg::ST_FOUND ||
             result.scan_status == hds_pkg::ST_NOT_FOUND ||
             result.scan_status == hds_pkg::ST_ZERO_LEN,
             "illegal scan status")

endmodule

### sim/usb_hid_descriptor_scanner_checker.sv
module usb_hid_descriptor_scanner_checker (
  input  logic clk,
  input  logic rst,
  hds_in_if    descriptor,
  hds_out_if   result,
  hds_cfg_if   cfg,
  output int   failures,
  output int   results_owed,
  output int   found_count,
  output int   miss_count,
  output int   zero_len_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // keep the log short on a badly broken run; the count stays exact
  localparam int REPORT_CAP = 40;

  logic [7:0] match_class;
  logic [7:0] desc_pos;
  logic [7:0] desc_size;
  logic [7:0] desc_kind;
  logic [7:0] iface_num;
  logic [7:0] ep_addr;
  logic       iface_hit;
  logic       blob_done;

  hds_pkg::hds_result_t due_results[$];

  task automatic report(input string what);
    if (failures < REPORT_CAP) begin
      $display("%0t ns: scanner mismatch: %s", $time, what);
    end
    failures++;
  endtask

  task automatic rearm_scan();
    desc_pos  = hds_pkg::OFF_LENGTH;
    desc_size = 8'h00;
    desc_kind = 8'h00;
    iface_num = 8'h00;
    iface_hit = 1'b0;
    ep_addr   = 8'h00;
    blob_done = 1'b0;
  endtask

  task automatic post_result(input hds_pkg::hds_status_t st, input logic [7:0] ifn,
                             input logic [7:0] ep);
    hds_pkg::hds_result_t r;
    r.scan_status      = st;
    r.iface_id         = ifn;
    r.endpoint_address = ep;
    due_results.push_back(r);
  endtask

  // Advances the descriptor walk by one byte; queues the blob's result if this byte makes it.
  task automatic scan_byte(input logic [7:0] b, input logic last);
    if (!blob_done) begin
      if (desc_pos == hds_pkg::OFF_LENGTH) begin
        desc_size = b;
        desc_kind = 8'h00;
        if (b == 8'h00) begin
          post_result(hds_pkg::ST_ZERO_LEN, 8'h00, 8'h00);
          blob_done = 1'b1;
        end
      end else if (desc_pos == hds_pkg::OFF_TYPE) begin
        desc_kind = b;
        if (b == hds_pkg::DESC_TYPE_INTERFACE) begin
          // a new interface drops any earlier match
          iface_num = 8'h00;
          iface_hit = 1'b0;
        end else if (b == hds_pkg::DESC_TYPE_ENDPOINT) begin
          ep_addr = 8'h00;
        end
      end else if (desc_kind == hds_pkg::DESC_TYPE_INTERFACE) begin
        if (desc_pos == hds_pkg::OFF_IF_NUM) begin
          iface_num = b;
        end else if (desc_pos == hds_pkg::OFF_IF_CLS) begin
          iface_hit = (b == match_class);
        end
      end else if (desc_kind == hds_pkg::DESC_TYPE_ENDPOINT && iface_hit) begin
        if (desc_pos == hds_pkg::OFF_EP_ADR) begin
          ep_addr = b;
        end else if (desc_pos == hds_pkg::OFF_EP_ATR &&
                     (b[1:0] & hds_pkg::EP_TYPE_MASK) == hds_pkg::EP_TYPE_INTERRUPT &&
                     ep_addr[hds_pkg::EP_DIR_IN_BIT]) begin
          post_result(hds_pkg::ST_FOUND, iface_num, ep_addr);
          blob_done = 1'b1;
        end
      end

      if (!blob_done) begin
        desc_pos = ({1'b0, desc_pos} + 9'd1 >= {1'b0, desc_size}) ? hds_pkg::OFF_LENGTH
                                                                   : desc_pos + 8'd1;
      end
      if (last && !blob_done) begin
        post_result(hds_pkg::ST_NOT_FOUND, 8'h00, 8'h00);
      end
    end
    if (last) begin
      rearm_scan();
    end
  endtask

  task automatic check_result();
    hds_pkg::hds_result_t want;
    if (due_results.size() == 0) begin
      report($sformatf("unexpected result: status %0d if %02h ep %02h",
                       result.scan_status, result.iface_id,
                       result.endpoint_address));
    end else begin
      want = due_results.pop_front();
      if (result.scan_status !== want.scan_status) begin
        report($sformatf("scan_status %0d, want %0d", result.scan_status, want.scan_status));
      end
      if (result.iface_id !== want.iface_id) begin
        report($sformatf("iface_id %02h, want %02h",
                         result.iface_id, want.iface_id));
      end
      if (result.endpoint_address !== want.endpoint_address) begin
        report($sformatf("endpoint_address %02h, want %02h",
                         result.endpoint_address, want.endpoint_address));
      end
      case (want.scan_status)
        hds_pkg::ST_FOUND:     found_count++;
        hds_pkg::ST_NOT_FOUND: miss_count++;
        default:               zero_len_count++;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_results.delete();
      match_class = hds_pkg::TARGET_CLASS_RESET;
      rearm_scan();
    end else begin
      // a result can't stem from a byte taken on the same edge, so results go first
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        check_result();
      end
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        match_class = cfg.target_class;
      end
      if (descriptor.valid === 1'b1 && descriptor.ready === 1'b1) begin
        scan_byte(descriptor.data_byte, descriptor.last_byte);
      end
    end
    results_owed <= due_results.size();
  end

endmodule

### sim/usb_hid_descriptor_scanner_tb.sv
module usb_hid_descriptor_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_BYTES = 1700;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [7:0] DESC_TYPE_CONFIG = 8'h02;
  localparam logic [7:0] DESC_TYPE_HID    = 8'h21;
  localparam logic [7:0] STD_DESC_LEN     = 8'd9;
  localparam logic [7:0] EP_DESC_LEN      = 8'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #CLK_HALF clk = ~clk;

  hds_in_if  descriptor ();
  hds_out_if result ();
  hds_cfg_if cfg ();

  int failures;
  int results_owed;
  int found_count;
  int miss_count;
  int zero_len_count;

  usb_hid_descriptor_scanner u_top (
    .clk        (clk),
    .rst        (rst),
    .descriptor (descriptor),
    .result     (result),
    .cfg        (cfg)
  );

  usb_hid_descriptor_scanner_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .descriptor     (descriptor),
    .result         (result),
    .cfg            (cfg),
    .failures       (failures),
    .results_owed   (results_owed),
    .found_count    (found_count),
    .miss_count     (miss_count),
    .zero_len_count (zero_len_count)
  );

  logic [7:0]         class_now;
  bit                 no_idle;
  int                 cycles;
  int                 ready_hold;
  int                 blobs_sent;
  int                 bytes_sent;
  hds_pkg::hds_item_t blob[$];
  logic [7:0]         desc_buf[$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, results_owed);
      $display("usb_hid_descriptor_scanner_tb NOT OK");
      $finish;
    end
  end

  // result side back-pressure: long ready runs, short stalls, now and then a long one
  always @(posedge clk) begin
    int roll;
    if (rst) begin
      result.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (no_idle) begin
      result.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        result.ready <= 1'b1;
        ready_hold   <= $urandom_range(0, 15);
      end else if (roll < 92) begin
        result.ready <= 1'b0;
        ready_hold   <= $urandom_range(0, 2);
      end else begin
        result.ready <= 1'b0;
        ready_hold   <= $urandom_range(8, 30);
      end
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void put(input logic [7:0] b);
    blob.push_back('{data_byte: b, last_byte: 1'b0});
  endfunction

  // trim or pad the descriptor being built to n bytes and make its length byte agree
  function automatic void fit_desc(input int n);
    while (desc_buf.size() > n) void'(desc_buf.pop_back());
    while (desc_buf.size() < n) desc_buf.push_back(rnd8());
    desc_buf[0] = 8'(n);
  endfunction

  function automatic void add_desc(input logic [7:0] kind, input bit loose);
    logic [7:0] adr;
    logic [7:0] atr;
    logic [7:0] cls;
    int         roll;
    adr = rnd8();
    adr[hds_pkg::EP_DIR_IN_BIT] = ($urandom_range(0, 99) < 70);
    atr = rnd8();
    if ($urandom_range(0, 99) < 60) atr[1:0] = hds_pkg::EP_TYPE_INTERRUPT;
    cls = ($urandom_range(0, 99) < 60) ? class_now : rnd8();
    case (kind)
      hds_pkg::DESC_TYPE_INTERFACE: begin
        desc_buf = {STD_DESC_LEN, kind, rnd8(), rnd8(), rnd8(), cls, rnd8(), rnd8(), rnd8()};
      end
      hds_pkg::DESC_TYPE_ENDPOINT: begin
        desc_buf = {EP_DESC_LEN, kind, adr, atr, rnd8(), rnd8(), rnd8()};
      end
      default: begin
        desc_buf = {STD_DESC_LEN, kind, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8()};
      end
    endcase
    roll = $urandom_range(0, 99);
    if (loose) begin
      fit_desc($urandom_range(1, 8));
    end else if (roll < 7) begin
      fit_desc($urandom_range(1, 12));
    end else if (roll < 8) begin
      fit_desc($urandom_range(200, 255));
    end else if (roll < 10) begin
      desc_buf.delete();
      desc_buf.push_back(8'h00);
    end
    foreach (desc_buf[i]) put(desc_buf[i]);
    desc_buf.delete();
  endfunction

  task automatic send_byte(input hds_pkg::hds_item_t it);
    int gap;
    int roll;
    descriptor.valid     <= 1'b1;
    descriptor.data_byte <= it.data_byte;
    descriptor.last_byte <= it.last_byte;
    do @(posedge clk); while (descriptor.ready !== 1'b1);
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      descriptor.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_blob();
    foreach (blob[i]) send_byte(blob[i]);
    blobs_sent++;
    bytes_sent += blob.size();
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    blob.delete();
    foreach (bytes[i]) put(bytes[i]);
    blob[$].last_byte = 1'b1;
    send_blob();
  endtask

  // stop the byte stream and let every owed result drain, then idle for DRAIN_CYCLES
  task automatic wait_idle();
    descriptor.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_class(input logic [7:0] v);
    cfg.valid        <= 1'b1;
    cfg.target_class <= v;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    class_now = v;
    repeat (2) @(posedge clk);
  endtask

  initial begin
    logic [7:0] phase_class [4];
    int         phase_bytes;
    int         roll;
    int         cut;
    descriptor.valid     <= 1'b0;
    descriptor.data_byte <= 8'h00;
    descriptor.last_byte <= 1'b0;
    cfg.valid            <= 1'b0;
    cfg.target_class     <= 8'h00;
    class_now = hds_pkg::TARGET_CLASS_RESET;
    no_idle   = 1'b0;
    phase_class = '{8'h00, 8'hFF, rnd8(), hds_pkg::TARGET_CLASS_RESET};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero length byte that is also the last byte
    send_bytes({8'h00});
    // matched interface, then a 2-byte interface clears it; blob ends on a length byte
    send_bytes({8'd6, hds_pkg::DESC_TYPE_INTERFACE, 8'd1, 8'd0, 8'd0,
                hds_pkg::TARGET_CLASS_RESET,
                8'd2, hds_pkg::DESC_TYPE_INTERFACE,
                8'd4, hds_pkg::DESC_TYPE_ENDPOINT, 8'h81, 8'h03,
                8'd5});
    // 3-byte endpoint is skipped; found on the last byte with all-ones fields
    send_bytes({8'd6, hds_pkg::DESC_TYPE_INTERFACE, 8'hFF, 8'd0, 8'd0,
                hds_pkg::TARGET_CLASS_RESET,
                8'd3, hds_pkg::DESC_TYPE_ENDPOINT, 8'h81,
                8'd4, hds_pkg::DESC_TYPE_ENDPOINT, 8'hFF, 8'hFF});
    // last byte after a zero length result gives nothing
    send_bytes({8'h00, 8'd9});
    wait_idle();

    foreach (phase_class[p]) begin
      write_class(phase_class[p]);
      phase_bytes = 0;
      while (phase_bytes < RANDOM_BYTES / 4) begin
        blob.delete();
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
          // mostly well-formed configuration with random content, sometimes cut short
          if ($urandom_range(0, 1) == 1) add_desc(DESC_TYPE_CONFIG, 1'b0);
          repeat ($urandom_range(1, 3)) begin
            add_desc(hds_pkg::DESC_TYPE_INTERFACE, 1'b0);
            if ($urandom_range(0, 99) < 30) add_desc(DESC_TYPE_HID, 1'b0);
            repeat ($urandom_range(0, 2)) add_desc(hds_pkg::DESC_TYPE_ENDPOINT, 1'b0);
          end
          if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, blob.size());
            while (blob.size() > cut) void'(blob.pop_back());
          end
        end else if (roll < 86) begin
          // runs of short descriptors
          repeat ($urandom_range(1, 6)) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) add_desc(hds_pkg::DESC_TYPE_INTERFACE, 1'b1);
            else if (roll < 80) add_desc(hds_pkg::DESC_TYPE_ENDPOINT, 1'b1);
            else add_desc(rnd8(), 1'b1);
          end
        end else begin
          repeat ($urandom_range(1, 16)) put(rnd8());
        end
        blob[$].last_byte = 1'b1;
        phase_bytes += blob.size();
        no_idle = ($urandom_range(0, 99) < 15);
        send_blob();
      end
      no_idle = 1'b0;
      wait_idle();
    end

    $display("scanned %0d blobs, %0d bytes; target class reset value, then %02h %02h %02h %02h",
             blobs_sent, bytes_sent, phase_class[0], phase_class[1], phase_class[2],
             phase_class[3]);
    $display("results: %0d found, %0d not found, %0d zero length; %0d mismatches",
             found_count, miss_count, zero_len_count, failures);
    if (failures == 0) begin
      $display("usb_hid_descriptor_scanner_tb OK");
    end else begin
      $display("usb_hid_descriptor_scanner_tb NOT OK");
    end
    $finish;
  end

endmodule
